### rtl/assert_macros.svh
// Assertion helpers for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/i2cseq_pkg.sv
`default_nettype none
package i2cseq_pkg;

    // input function codes
    typedef enum logic [1:0] {
        FUNC_START_RD = 2'd0,
        FUNC_START_WR = 2'd1,
        FUNC_EVENT    = 2'd2,
        FUNC_RSVD     = 2'd3
    } t_func;

    // bus core commands
    typedef enum logic [3:0] {
        CMD_NONE  = 4'd0,
        CMD_ADDR  = 4'd1,
        CMD_DATA  = 4'd2,
        CMD_RECV  = 4'd3,
        CMD_STOP  = 4'd4,
        CMD_NSTOP = 4'd5,
        CMD_NRRD  = 4'd6,
        CMD_NRWR  = 4'd7,
        CMD_FLUSH = 4'd8
    } t_cmd;

    // follow-up phase codes
    typedef enum logic [1:0] {
        FOLLOW_STOP     = 2'd0,
        FOLLOW_CONT_WR  = 2'd1,
        FOLLOW_RSTRT_RD = 2'd2,
        FOLLOW_RSTRT_WR = 2'd3
    } t_follow;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_DEVICE_ADDRESS = 2'd0,
        REG_FIRST_LENGTH   = 2'd1,
        REG_FOLLOW_OP      = 2'd2,
        REG_FOLLOW_LENGTH  = 2'd3
    } t_reg_idx;

    localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd127;
    localparam logic [7:0] FIRST_LENGTH_RST   = 8'd1;
    localparam logic [7:0] FOLLOW_LENGTH_RST  = 8'd1;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] tx_byte;
        logic [7:0] rx_byte;
        logic       rx_nack;
        logic       arb_lost;
        logic       bus_fault;
    } t_in_item;

    typedef struct packed {
        logic [3:0] core_cmd;
        logic [7:0] addr_byte;
        logic [7:0] data_byte;
        logic       rx_valid;
        logic       busy_res;
        logic       fail;
        logic       refused;
    } t_out_item;

    typedef struct packed {
        logic [6:0] device_address;
        logic [7:0] first_length;
        t_follow    follow_op;
        logic [7:0] follow_length;
    } t_cfg;

endpackage
`default_nettype wire

### rtl/i2cseq_cfg.sv
`default_nettype none
module i2cseq_cfg (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [7:0]            i_cfg_data,
    output i2cseq_pkg::t_cfg           o_cfg
);
    import i2cseq_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= DEVICE_ADDRESS_RST;
            r_cfg.first_length   <= FIRST_LENGTH_RST;
            r_cfg.follow_op      <= FOLLOW_STOP;
            r_cfg.follow_length  <= FOLLOW_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_DEVICE_ADDRESS: r_cfg.device_address <= i_cfg_data[6:0];
                REG_FIRST_LENGTH:   r_cfg.first_length   <= i_cfg_data;
                REG_FOLLOW_OP:      r_cfg.follow_op      <= t_follow'(i_cfg_data[1:0]);
                REG_FOLLOW_LENGTH:  r_cfg.follow_length  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

### rtl/i2cseq_step.sv
`default_nettype none
module i2cseq_step (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_go,
    input  wire i2cseq_pkg::t_in_item  i_item,
    input  wire i2cseq_pkg::t_cfg      i_cfg,
    output i2cseq_pkg::t_out_item      o_res
);
    import i2cseq_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_RX     = 2'd1,
        PH_TX     = 2'd2,
        PH_TXDONE = 2'd3
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic       r_addr_chk, n_addr_chk;
    logic       r_busy, n_busy;
    logic       r_fail, n_fail;
    logic       r_follow, n_follow;

    t_out_item  res;
    logic [7:0] rx_dec;
    logic [7:0] tx_base;
    logic [7:0] tx_dec;
    logic [7:0] addr_wr;
    logic [7:0] addr_rd;

    assign rx_dec  = r_bytes_left - 8'd1;
    // a follow-on write starts counting from the follow-up length
    assign tx_base = (r_phase == PH_TXDONE) ? i_cfg.follow_length : r_bytes_left;
    assign tx_dec  = tx_base - 8'd1;
    assign addr_wr = {i_cfg.device_address, 1'b0};
    assign addr_rd = {i_cfg.device_address, 1'b1};

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_addr_chk   = r_addr_chk;
        n_busy       = r_busy;
        n_fail       = r_fail;
        n_follow     = r_follow;
        res          = '0;
        res.core_cmd = CMD_NONE;

        case (t_func'(i_item.func))
            FUNC_START_RD, FUNC_START_WR: begin
                if (r_busy) begin
                    res.refused = 1'b1;
                end else begin
                    n_busy       = 1'b1;
                    n_fail       = 1'b0;
                    n_follow     = 1'b0;
                    n_bytes_left = i_cfg.first_length;
                    n_addr_chk   = 1'b1;
                    res.core_cmd = CMD_ADDR;
                    if (t_func'(i_item.func) == FUNC_START_RD) begin
                        res.addr_byte = addr_rd;
                        n_phase       = PH_RX;
                    end else begin
                        res.addr_byte = addr_wr;
                        n_phase       = PH_TX;
                    end
                end
            end
            FUNC_EVENT: begin
                if (r_busy) begin
                    if (i_item.bus_fault || i_item.arb_lost
                            || (r_addr_chk && i_item.rx_nack)) begin
                        if (i_item.bus_fault)
                            res.core_cmd = CMD_FLUSH;
                        else if (!i_item.arb_lost)
                            res.core_cmd = CMD_STOP;
                        n_phase    = PH_IDLE;
                        n_busy     = 1'b0;
                        n_addr_chk = 1'b0;
                        n_fail     = 1'b1;
                    end else begin
                        unique case (r_phase)
                            PH_TX, PH_TXDONE: begin
                                if (i_item.rx_nack || (r_phase == PH_TXDONE
                                        && (r_follow || i_cfg.follow_op == FOLLOW_STOP))) begin
                                    res.core_cmd = CMD_STOP;
                                    n_phase      = PH_IDLE;
                                    n_busy       = 1'b0;
                                    n_addr_chk   = 1'b0;
                                    n_fail       = 1'b0;
                                end else if (r_phase == PH_TX
                                        || i_cfg.follow_op == FOLLOW_CONT_WR) begin
                                    if (r_phase == PH_TXDONE)
                                        n_follow = 1'b1;
                                    n_addr_chk    = 1'b0;
                                    res.core_cmd  = CMD_DATA;
                                    res.data_byte = i_item.tx_byte;
                                    n_bytes_left  = tx_dec;
                                    n_phase       = (tx_dec != 8'd0) ? PH_TX : PH_TXDONE;
                                end else begin
                                    n_follow     = 1'b1;
                                    n_bytes_left = i_cfg.follow_length;
                                    n_addr_chk   = 1'b1;
                                    if (i_cfg.follow_op == FOLLOW_RSTRT_RD) begin
                                        res.core_cmd  = CMD_NRRD;
                                        res.addr_byte = addr_rd;
                                        n_phase       = PH_RX;
                                    end else begin
                                        res.core_cmd  = CMD_NRWR;
                                        res.addr_byte = addr_wr;
                                        n_phase       = PH_TX;
                                    end
                                end
                            end
                            PH_RX: begin
                                n_addr_chk    = 1'b0;
                                res.data_byte = i_item.rx_byte;
                                res.rx_valid  = 1'b1;
                                n_bytes_left  = rx_dec;
                                if (rx_dec != 8'd0) begin
                                    res.core_cmd = CMD_RECV;
                                end else if (!r_follow
                                        && i_cfg.follow_op == FOLLOW_RSTRT_RD) begin
                                    n_follow      = 1'b1;
                                    n_bytes_left  = i_cfg.follow_length;
                                    n_addr_chk    = 1'b1;
                                    res.core_cmd  = CMD_NRRD;
                                    res.addr_byte = addr_rd;
                                end else if (!r_follow
                                        && i_cfg.follow_op == FOLLOW_RSTRT_WR) begin
                                    n_follow      = 1'b1;
                                    n_bytes_left  = i_cfg.follow_length;
                                    n_addr_chk    = 1'b1;
                                    res.core_cmd  = CMD_NRWR;
                                    res.addr_byte = addr_wr;
                                    n_phase       = PH_TX;
                                end else begin
                                    // a continue-write after a read also ends here
                                    res.core_cmd = CMD_NSTOP;
                                    n_phase      = PH_IDLE;
                                    n_busy       = 1'b0;
                                end
                            end
                            PH_IDLE: begin
                                // busy without a phase: settle, keep fail
                                n_busy     = 1'b0;
                                n_addr_chk = 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            default: ;
        endcase

        res.busy_res = n_busy;
        res.fail     = n_fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bytes_left <= '0;
            r_addr_chk   <= 1'b0;
            r_busy       <= 1'b0;
            r_fail       <= 1'b0;
            r_follow     <= 1'b0;
        end else if (i_go) begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_addr_chk   <= n_addr_chk;
            r_busy       <= n_busy;
            r_fail       <= n_fail;
            r_follow     <= n_follow;
        end
    end

    assign o_res = res;

endmodule
`default_nettype wire

### rtl/i2c_master_transaction_sequencer.sv
// channel   dir  handshake                    payload
// in        in   i_in_valid / o_in_stall      i_in_data  (t_in_item)
// out       out  o_out_valid / i_out_stall    o_out_data (t_out_item)
// cfg       in   i_cfg_we                     i_cfg_index, i_cfg_data
//
// One transaction per cycle sustained while the result is not stalled; a transaction
// passes the input register, then the step logic into the result register.
// Synchronous active-low reset puts the sequencer idle with configuration registers at defaults.
// A stalled result holds in the result register; the input register still takes
// one more transaction, then o_in_stall rises until the result is taken.
`default_nettype none
`include "assert_macros.svh"
module i2c_master_transaction_sequencer (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire i2cseq_pkg::t_in_item  i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output i2cseq_pkg::t_out_item      o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [7:0]            i_cfg_data
);
    import i2cseq_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_data;
    logic      r_out_valid;
    t_out_item r_out_data;

    t_cfg      cfg;
    t_out_item step_res;
    logic      advance;

    logic      out_fail;
    logic      out_busy;
    logic      out_refused;
    logic      out_rx;
    logic      refused_ok;
    logic      rx_cmd_ok;
    logic      both_full;

    assign advance    = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;

    i2cseq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    i2cseq_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (advance),
        .i_item  (r_in_data),
        .i_cfg   (cfg),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall)
            r_in_data <= i_in_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance)
            r_out_data <= step_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign out_fail    = r_out_valid && r_out_data.fail;
    assign out_busy    = r_out_data.busy_res;
    assign out_refused = r_out_valid && r_out_data.refused;
    assign out_rx      = r_out_valid && r_out_data.rx_valid;
    assign refused_ok  = (r_out_data.core_cmd == CMD_NONE) && r_out_data.busy_res;
    assign rx_cmd_ok   = (r_out_data.core_cmd == CMD_RECV) || (r_out_data.core_cmd == CMD_NSTOP)
                      || (r_out_data.core_cmd == CMD_NRRD) || (r_out_data.core_cmd == CMD_NRWR);
    assign both_full   = r_in_valid && r_out_valid;

    `ASSERT_IMPL(a_fail_not_busy, i_clk, i_rst_n, out_fail, !out_busy, "fail while busy")
    `ASSERT_IMPL(a_refused_no_cmd, i_clk, i_rst_n, out_refused, refused_ok, "refused start acted")
    `ASSERT_IMPL(a_rx_cmd, i_clk, i_rst_n, out_rx, rx_cmd_ok, "received byte with wrong command")
    `ASSERT_AT(a_stall_full, i_clk, i_rst_n, !o_in_stall || both_full, "stall with free slot")

endmodule
`default_nettype wire
